FILE: src/wildcard_glob_matcher_assert.svh
// Assertion macros used by the wildcard glob matcher checker.
// Depends on nothing; files that assert include it by name.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define WGM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define WGM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wgm_pkg.sv
// Shared types, constants and helper functions for the wildcard glob matcher.
// Depends on nothing; the store, active-set and top modules import it.
package wgm_pkg;

  localparam int MAX_PATTERN_CHARS = 63;
  localparam int POS_W = MAX_PATTERN_CHARS + 1;
  localparam int LEN_W = $clog2(MAX_PATTERN_CHARS + 1);

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_TEXT   = 2'd1,
    ACT_END    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef logic [MAX_PATTERN_CHARS-1:0][7:0] pat_bytes_t;

  // Command to the pattern store.
  typedef struct packed {
    logic       append;
    logic       clear;
    logic [7:0] char_value;
  } pat_cmd_t;

  // Pattern summary seen by the active-set logic.
  typedef struct packed {
    logic [POS_W-1:0] star_mask;
    logic [POS_W-1:0] live_mask;
    logic [LEN_W-1:0] len;
  } pat_status_t;

  // Command to the active-set logic.
  typedef struct packed {
    logic       restart;
    logic       consume;
    logic [7:0] char_value;
  } text_cmd_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
    logic [7:0] r;
    r = c;
    if (fold_en && c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

endpackage

FILE: src/wgm_in_if.sv
// Input channel of the wildcard glob matcher: valid/ready plus one item.
// Depends on nothing.
interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_value;

  modport source (output valid, output action, output char_value, input ready);
  modport sink   (input valid, input action, input char_value, output ready);
endinterface

FILE: src/wgm_out_if.sv
// Result channel of the wildcard glob matcher: valid/ready plus the match bit.
// Depends on nothing.
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

FILE: src/wgm_pattern_store.sv
// Pattern registers of the glob matcher, with length and per-position masks.
// Depends on wgm_pkg.
module wgm_pattern_store
  import wgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pat_cmd_t    cmd,
  output pat_bytes_t  pat,
  output pat_status_t status
);

  logic [LEN_W-1:0] len;
  logic [POS_W-1:0] star_mask;
  logic [POS_W-1:0] live_mask;
  logic             room;

  assign room = len < LEN_W'(MAX_PATTERN_CHARS);

  // Pattern bytes carry no reset; only entries below the length are ever used.
  always_ff @(posedge clk) begin
    if (cmd.append && room) begin
      pat[len] <= cmd.char_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      star_mask <= '0;
      live_mask <= '0;
    end else if (cmd.clear) begin
      len       <= '0;
      star_mask <= '0;
      live_mask <= '0;
    end else if (cmd.append && room) begin
      len            <= len + LEN_W'(1);
      star_mask[len] <= (cmd.char_value == STAR_CHAR);
      live_mask[len] <= 1'b1;
    end
  end

  assign status.star_mask = star_mask;
  assign status.live_mask = live_mask;
  assign status.len       = len;

endmodule

FILE: src/wgm_active_set.sv
// Bit-parallel set of active pattern positions and the match bit it gives.
// Depends on wgm_pkg.
module wgm_active_set
  import wgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        case_fold,
  input  pat_bytes_t  pat,
  input  pat_status_t status,
  input  text_cmd_t   cmd,
  output logic        match_bit
);

  // The register holds the set before star closure; closure is applied on read
  // so that it always uses the current pattern.
  logic [POS_W-1:0]             raw;
  logic [POS_W-1:0]             raw_next;
  logic [POS_W-1:0]             gen;
  logic [POS_W-1:0]             carry_sum;
  logic [POS_W-1:0]             closed;
  logic [MAX_PATTERN_CHARS-1:0] hit;
  logic [7:0]                   text_folded;

  // A run of stars propagates an active bit like a carry: stars propagate,
  // active stars generate.
  assign gen       = raw & status.star_mask;
  assign carry_sum = status.star_mask + gen;
  assign closed    = raw | (carry_sum ^ status.star_mask ^ gen);

  assign text_folded = fold_byte(cmd.char_value, case_fold);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
      hit[i] = (pat[i] == ANY_CHAR) || (fold_byte(pat[i], case_fold) == text_folded);
    end
  end

  always_comb begin
    raw_next = (closed & status.star_mask)
             | {hit & closed[MAX_PATTERN_CHARS-1:0] & status.live_mask[MAX_PATTERN_CHARS-1:0]
                & ~status.star_mask[MAX_PATTERN_CHARS-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      raw <= POS_W'(1);
    end else if (cmd.consume) begin
      raw <= raw_next;
    end
  end

  assign match_bit = closed[status.len];

endmodule

FILE: src/wildcard_glob_matcher.sv
// The match bit is registered when its end-of-text item leaves the working register.
// Throughput: one item per cycle; the only stall is an end-of-text item held
// in the working register while the result register still waits for a transfer.
// Reset: pattern empty, case folding on, active set at position zero, result
// register empty. No clearing pass; the block takes items right after reset.
module wildcard_glob_matcher
  import wgm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  wgm_in_if.sink    item,
  wgm_out_if.source result
);

  logic        case_fold;
  logic        stage_valid;
  action_t     stage_action;
  logic [7:0]  stage_char;
  logic        fire;
  logic        result_valid;
  logic        matched;
  logic        match_bit;
  pat_cmd_t    pat_cmd;
  text_cmd_t   text_cmd;
  pat_bytes_t  pat;
  pat_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b1;
    end else if (cfg_we) begin
      case_fold <= cfg_data;
    end
  end

  // An end-of-text item can only retire when the result register is free or being read.
  assign fire = stage_valid &&
                (stage_action != ACT_END || !result_valid || result.ready);
  assign item.ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_action <= action_t'(item.action);
      stage_char   <= item.char_value;
    end
  end

  always_comb begin
    pat_cmd.append      = 1'b0;
    pat_cmd.clear       = 1'b0;
    pat_cmd.char_value  = stage_char;
    text_cmd.restart    = 1'b0;
    text_cmd.consume    = 1'b0;
    text_cmd.char_value = stage_char;
    if (fire) begin
      case (stage_action)
        ACT_APPEND: begin
          pat_cmd.append   = 1'b1;
          text_cmd.restart = 1'b1;
        end
        ACT_TEXT: begin
          text_cmd.consume = 1'b1;
        end
        ACT_END: begin
          text_cmd.restart = 1'b1;
        end
        ACT_CLEAR: begin
          pat_cmd.clear    = 1'b1;
          text_cmd.restart = 1'b1;
        end
        default: begin
          text_cmd.restart = 1'b1;
        end
      endcase
    end
  end

  wgm_pattern_store u_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (pat_cmd),
    .pat    (pat),
    .status (status)
  );

  wgm_active_set u_active (
    .clk       (clk),
    .rst       (rst),
    .case_fold (case_fold),
    .pat       (pat),
    .status    (status),
    .cmd       (text_cmd),
    .match_bit (match_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && stage_action == ACT_END) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stage_action == ACT_END) begin
      matched <= match_bit;
    end
  end

  assign result.valid   = result_valid;
  assign result.matched = matched;

endmodule

FILE: src/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wildcard_glob_matcher_assert.svh and the top-level ports.
`include "wildcard_glob_matcher_assert.svh"

module wgm_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready,
  input logic matched
);

  // With the result register empty, nothing can hold back the input.
  `WGM_ASSERT(a_ready_when_result_free, (!result_valid |-> item_ready), "input stalled")
  // Reset leaves no result pending.
  `WGM_ASSERT_ALWAYS(a_reset_empties_result, (rst |=> !result_valid), "result after reset")
  `WGM_ASSERT(a_result_held, (result_valid && !result_ready |=> result_valid), "result dropped")
  `WGM_ASSERT(a_match_stable, (result_valid && !result_ready |=> $stable(matched)), "match moved")

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .matched      (result.matched)
);

FILE: test/tb_top.sv
// Self-checking testbench for wildcard_glob_matcher: directed and random patterns
// and texts go in; every match bit is checked against an active-position-set predictor.
// Depends on wgm_pkg, wgm_in_if, wgm_out_if and the wildcard_glob_matcher RTL.
`timescale 1ns / 1ps

module tb_top;
  import wgm_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 410;
  localparam int unsigned HOLD_AFTER      = 30;
  localparam int unsigned HOLD_CYCLES     = 400;

  typedef struct packed {
    action_t    act;
    logic [7:0] ch;
  } glob_cmd_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  wgm_in_if  in_bus ();
  wgm_out_if out_bus ();

  wildcard_glob_matcher u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .item    (in_bus),
    .result  (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the matcher.
  logic [7:0]       glob_pat [MAX_PATTERN_CHARS];
  int unsigned      glob_len;
  logic [POS_W-1:0] glob_live;
  logic             glob_fold;
  logic             pending_matches [$];

  // Stimulus bookkeeping.
  glob_cmd_t   cmd_queue [$];
  logic [7:0]  shadow_pat [$];
  int unsigned items_pushed;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned cycle_count;

  // Sender and receiver pacing.
  glob_cmd_t   next_cmd;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  int unsigned hold_left;
  bit          hold_done;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (glob_fold && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  // A star at an active position also makes the position after it active.
  function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] s);
    logic [POS_W-1:0] r;
    r = s;
    for (int i = 0; i < glob_len; i++) begin
      if (glob_pat[i] == STAR_CHAR && r[i]) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void glob_step(input action_t act, input logic [7:0] ch);
    logic [POS_W-1:0] nxt;
    nxt = '0;
    case (act)
      ACT_APPEND: begin
        if (glob_len < MAX_PATTERN_CHARS) begin
          glob_pat[glob_len] = ch;
          glob_len++;
        end
        glob_live = close_stars(POS_W'(1));
      end
      ACT_TEXT: begin
        for (int i = 0; i < glob_len; i++) begin
          if (glob_live[i]) begin
            if (glob_pat[i] == STAR_CHAR) begin
              nxt[i] = 1'b1;
            end else if (glob_pat[i] == ANY_CHAR || fold_case(glob_pat[i]) == fold_case(ch)) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        glob_live = close_stars(nxt);
      end
      ACT_END: begin
        pending_matches.push_back(glob_live[glob_len]);
        glob_live = close_stars(POS_W'(1));
      end
      default: begin
        glob_len  = 0;
        glob_live = close_stars(POS_W'(1));
      end
    endcase
  endfunction

  function automatic void push_cmd(input action_t act, input logic [7:0] ch);
    glob_cmd_t c;
    c.act = act;
    c.ch  = ch;
    cmd_queue.push_back(c);
    items_pushed++;
    if (act == ACT_APPEND && shadow_pat.size() < MAX_PATTERN_CHARS) begin
      shadow_pat.push_back(ch);
    end else if (act == ACT_CLEAR) begin
      shadow_pat.delete();
    end
  endfunction

  // Mostly a few letters of either case so that literals hit; wildcards only when asked.
  function automatic logic [7:0] random_char(input bit with_wild);
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (with_wild && r < 20) begin
      c = STAR_CHAR;
    end else if (with_wild && r < 35) begin
      c = ANY_CHAR;
    end else if (r < 85) begin
      c = 8'h61 + 8'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) begin
        c = c ^ CASE_GAP;
      end
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Well-formed pattern/text sequences with random content, plus some noise.
  // A text is built to fit the pattern and then sometimes broken at one place.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned plen;
    int          mut_pos;
    int unsigned mut_kind;
    logic [7:0]  c;
    logic [7:0]  lower;
    start = items_pushed;
    while (items_pushed - start < n_items) begin
      if ($urandom_range(0, 99) < 78) begin
        if ($urandom_range(0, 4) != 0) begin
          push_cmd(ACT_CLEAR, 8'($urandom_range(0, 255)));
        end
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 7);
        repeat (plen) push_cmd(ACT_APPEND, random_char(1'b1));
        repeat ($urandom_range(1, 3)) begin
          mut_pos  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, shadow_pat.size())) : -1;
          mut_kind = $urandom_range(0, 2);
          for (int i = 0; i <= shadow_pat.size(); i++) begin
            if (i == mut_pos && mut_kind != 0) begin
              push_cmd(ACT_TEXT, random_char(1'b0));
            end
            if (i == shadow_pat.size()) begin
              break;
            end
            if (i == mut_pos && mut_kind != 1) begin
              continue;
            end
            c = shadow_pat[i];
            if (c == STAR_CHAR) begin
              repeat ($urandom_range(0, 3)) push_cmd(ACT_TEXT, random_char(1'b0));
            end else if (c == ANY_CHAR) begin
              push_cmd(ACT_TEXT, random_char(1'b0));
            end else begin
              lower = c | CASE_GAP;
              if (lower >= UPPER_A + CASE_GAP && lower <= UPPER_Z + CASE_GAP &&
                  $urandom_range(0, 3) == 0) begin
                c = c ^ CASE_GAP;
              end
              push_cmd(ACT_TEXT, c);
            end
          end
          push_cmd(ACT_END, 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_cmd(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Items that cause no result may still be in the pipeline, so the task keeps
  // waiting after the last match bit has come back.
  task automatic wait_idle();
    while (!(items_accepted == items_pushed && pending_matches.size() == 0)) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    glob_fold = v;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        glob_step(action_t'(in_bus.action), in_bus.char_value);
        items_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          next_cmd = cmd_queue.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.action     <= next_cmd.act;
          in_bus.char_value <= next_cmd.ch;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold.
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      rx_mode_left  = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_bus.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(32, 256);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_OPEN:   out_bus.ready <= 1'b1;
        RX_COIN:   out_bus.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_bus.ready <= ($urandom_range(0, 3) == 0);
        default:   out_bus.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Every result transfer is checked against the oldest predicted match bit.
  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_matches.size() == 0) begin
        $error("matched: no result expected, actual %0b", out_bus.matched);
        error_count++;
      end else if (out_bus.matched !== pending_matches[0]) begin
        $error("matched: expected %0b, actual %0b", pending_matches[0], out_bus.matched);
        error_count++;
        void'(pending_matches.pop_front());
      end else begin
        void'(pending_matches.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    logic fold_plan [4];
    fold_plan = '{1'b0, 1'b1, 1'b0, 1'b1};
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_CLEAR;
    in_bus.char_value = 8'h00;
    out_bus.ready     = 1'b0;
    items_pushed      = 0;
    items_accepted    = 0;
    results_seen      = 0;
    error_count       = 0;
    cycle_count       = 0;
    glob_len          = 0;
    glob_fold         = 1'b1;
    glob_live         = POS_W'(1);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with case folding at its reset value.
    push_cmd(ACT_END, 8'h00);
    push_cmd(ACT_TEXT, 8'h00);
    push_cmd(ACT_END, 8'hFF);
    push_cmd(ACT_APPEND, STAR_CHAR);
    push_cmd(ACT_END, 8'h00);
    push_cmd(ACT_APPEND, "A");
    push_cmd(ACT_TEXT, "x");
    push_cmd(ACT_TEXT, "a");
    push_cmd(ACT_END, 8'h00);
    // An append in the middle of a text drops that text.
    push_cmd(ACT_TEXT, "b");
    push_cmd(ACT_APPEND, ANY_CHAR);
    push_cmd(ACT_TEXT, "z");
    push_cmd(ACT_TEXT, "A");
    push_cmd(ACT_TEXT, 8'hFF);
    push_cmd(ACT_END, 8'h00);
    // A zero byte is an ordinary character on both sides.
    push_cmd(ACT_CLEAR, 8'hFF);
    push_cmd(ACT_APPEND, 8'h00);
    push_cmd(ACT_TEXT, 8'h00);
    push_cmd(ACT_END, 8'h00);
    push_cmd(ACT_END, 8'hAA);
    push_cmd(ACT_TEXT, 8'h80);
    push_cmd(ACT_CLEAR, 8'h00);
    push_cmd(ACT_END, 8'h55);

    // The sender pauses here until every expected result has come back.
    foreach (fold_plan[p]) begin
      wait_idle();
      write_fold(fold_plan[p]);
      run_random_phase(ITEMS_PER_PHASE);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_matches.size() != 0) begin
      $error("matched: %0d expected results never arrived", pending_matches.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
